// ----- rtl/core/pmt_pkg.sv -----
// Shared types and constants for the PMT section parser.
// Used by pmt_parse_core and pmt_section_parser_top; no dependencies.
package pmt_pkg;

  // Parser phases, one-hot.
  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_HEADER    = 10'b00_0000_0010,
    PH_SKIP_PROG = 10'b00_0000_0100,
    PH_BOUNDARY  = 10'b00_0000_1000,
    PH_PID_HI    = 10'b00_0001_0000,
    PH_PID_LO    = 10'b00_0010_0000,
    PH_LEN_HI    = 10'b00_0100_0000,
    PH_LEN_LO    = 10'b00_1000_0000,
    PH_SKIP_ES   = 10'b01_0000_0000,
    PH_CRC       = 10'b10_0000_0000
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_STREAM   = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_PROG_OVERRUN  = 3'd1;
  localparam logic [2:0] ERR_STREAM_OVERRUN = 3'd2;
  localparam logic [2:0] ERR_LEFTOVER      = 3'd3;
  localparam logic [2:0] ERR_TOO_SHORT     = 3'd4;

  // Header byte positions.
  localparam logic [12:0] POS_LEN_HI   = 13'd1;
  localparam logic [12:0] POS_LEN_LO   = 13'd2;
  localparam logic [12:0] POS_PROG_HI  = 13'd3;
  localparam logic [12:0] POS_PROG_LO  = 13'd4;
  localparam logic [12:0] POS_PCR_HI   = 13'd8;
  localparam logic [12:0] POS_PCR_LO   = 13'd9;
  localparam logic [12:0] POS_PINFO_HI = 13'd10;
  localparam logic [12:0] POS_PINFO_LO = 13'd11;

  localparam int CRC_BYTES    = 4;
  localparam int ENTRY_BYTES  = 5;
  localparam int HEADER_BYTES = 12;

  // One result item plus a flag that says the byte produced it.
  typedef struct packed {
    logic        emit;
    logic [1:0]  result_kind;
    logic [15:0] prog_num;
    logic [12:0] pid;
    logic [7:0]  es_type;
    logic [11:0] info_length;
    logic [2:0]  error_code;
  } result_t;

endpackage

// ----- rtl/core/pmt_parse_core.sv -----
// Parser state and per-byte next-state logic for the PMT section parser.
// Depends on pmt_pkg.
module pmt_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             section_start,
  output pmt_pkg::result_t res
);
  import pmt_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [12:0] byte_position, byte_position_next;
  logic [12:0] section_end, section_end_next;
  logic [11:0] skip_remaining, skip_remaining_next;
  logic [7:0]  field_hold, field_hold_next;
  logic [12:0] held_pid, held_pid_next;
  logic [7:0]  held_stream_type, held_stream_type_next;
  logic [15:0] held_program_number, held_program_number_next;

  phase_t      phase_eff;
  logic [12:0] pos;
  logic [12:0] new_end;
  logic [11:0] len;
  logic [13:0] pos_wide;
  logic [13:0] end_wide;

  always_comb begin
    parse_phase_next         = parse_phase;
    byte_position_next       = byte_position;
    section_end_next         = section_end;
    skip_remaining_next      = skip_remaining;
    field_hold_next          = field_hold;
    held_pid_next            = held_pid;
    held_stream_type_next    = held_stream_type;
    held_program_number_next = held_program_number;
    res                      = '0;

    phase_eff = section_start ? PH_HEADER : parse_phase;
    pos       = section_start ? 13'd0 : byte_position;
    pos_wide  = {1'b0, pos};
    end_wide  = {1'b0, section_end};
    new_end   = 13'({1'b0, field_hold[3:0], data_byte}) + 13'd3;
    len       = {field_hold[3:0], data_byte};

    if (section_start) begin
      parse_phase_next = PH_HEADER;
    end
    if (phase_eff != PH_IDLE) begin
      byte_position_next = pos + 13'd1;
    end

    case (phase_eff)
      PH_HEADER: begin
        case (pos)
          POS_LEN_HI, POS_PROG_HI, POS_PCR_HI, POS_PINFO_HI: begin
            field_hold_next = data_byte;
          end
          POS_LEN_LO: begin
            section_end_next = new_end;
            if (new_end < 13'(HEADER_BYTES + CRC_BYTES)) begin
              parse_phase_next = PH_IDLE;
              res.emit         = 1'b1;
              res.result_kind  = KIND_ERROR;
              res.error_code   = ERR_TOO_SHORT;
            end
          end
          POS_PROG_LO: begin
            held_program_number_next = {field_hold, data_byte};
          end
          POS_PCR_LO: begin
            held_pid_next = {field_hold[4:0], data_byte};
          end
          POS_PINFO_LO: begin
            if (len != 12'd0 &&
                (14'(HEADER_BYTES + CRC_BYTES) + {2'b0, len}) > end_wide) begin
              parse_phase_next = PH_IDLE;
              res.emit         = 1'b1;
              res.result_kind  = KIND_ERROR;
              res.error_code   = ERR_PROG_OVERRUN;
            end else begin
              skip_remaining_next = len;
              parse_phase_next    = (len != 12'd0) ? PH_SKIP_PROG : PH_BOUNDARY;
              res.emit            = 1'b1;
              res.result_kind     = KIND_HEADER;
              res.prog_num        = held_program_number;
              res.pid             = held_pid;
              res.info_length     = len;
            end
          end
          default: begin
          end
        endcase
      end
      PH_SKIP_PROG, PH_SKIP_ES: begin
        skip_remaining_next = skip_remaining - 12'd1;
        if (skip_remaining == 12'd1) begin
          parse_phase_next = PH_BOUNDARY;
        end
      end
      PH_BOUNDARY: begin
        if ((pos_wide + 14'(CRC_BYTES + ENTRY_BYTES)) <= end_wide) begin
          held_stream_type_next = data_byte;
          parse_phase_next      = PH_PID_HI;
        end else if ((pos_wide + 14'(CRC_BYTES)) == end_wide) begin
          parse_phase_next = PH_CRC;
        end else begin
          parse_phase_next = PH_IDLE;
          res.emit         = 1'b1;
          res.result_kind  = KIND_ERROR;
          res.error_code   = ERR_LEFTOVER;
        end
      end
      PH_PID_HI: begin
        field_hold_next  = data_byte;
        parse_phase_next = PH_PID_LO;
      end
      PH_PID_LO: begin
        held_pid_next    = {field_hold[4:0], data_byte};
        parse_phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        field_hold_next  = data_byte;
        parse_phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if ((pos_wide + 14'(1 + CRC_BYTES) + {2'b0, len}) > end_wide) begin
          parse_phase_next = PH_IDLE;
          res.emit         = 1'b1;
          res.result_kind  = KIND_ERROR;
          res.error_code   = ERR_STREAM_OVERRUN;
        end else begin
          skip_remaining_next = len;
          parse_phase_next    = (len != 12'd0) ? PH_SKIP_ES : PH_BOUNDARY;
          res.emit            = 1'b1;
          res.result_kind     = KIND_STREAM;
          res.prog_num        = held_program_number;
          res.pid             = held_pid;
          res.es_type         = held_stream_type;
          res.info_length     = len;
        end
      end
      PH_CRC: begin
        if ((pos_wide + 14'd1) >= end_wide) begin
          parse_phase_next   = PH_IDLE;
          res.emit           = 1'b1;
          res.result_kind    = KIND_COMPLETE;
          res.prog_num       = held_program_number;
        end
      end
      PH_IDLE: begin
      end
      default: begin
        parse_phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_IDLE;
      byte_position       <= '0;
      section_end         <= '0;
      skip_remaining      <= '0;
      field_hold          <= '0;
      held_pid            <= '0;
      held_stream_type    <= '0;
      held_program_number <= '0;
    end else if (step) begin
      parse_phase         <= parse_phase_next;
      byte_position       <= byte_position_next;
      section_end         <= section_end_next;
      skip_remaining      <= skip_remaining_next;
      field_hold          <= field_hold_next;
      held_pid            <= held_pid_next;
      held_stream_type    <= held_stream_type_next;
      held_program_number <= held_program_number_next;
    end
  end

endmodule

// ----- rtl/core/pmt_section_parser_top.sv -----
// PMT section parser top level: input register, parser core, result register.
// Depends on pmt_pkg and pmt_parse_core.
// An accepted byte waits in the input register; its result is registered as it retires.
// Throughput: one byte per cycle; a byte stalls only while it would produce a
// result and the result register still holds one that has not been taken.
// Reset (rst, synchronous, active high) empties both registers and puts the parser idle.
module pmt_section_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [15:0] prog_num,
  output logic [12:0] pid,
  output logic [7:0]  es_type,
  output logic [11:0] info_length,
  output logic [2:0]  error_code
);
  import pmt_pkg::*;

  // Input register: holds the accepted byte while the core works on it.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_start;

  result_t res;
  logic    out_free;
  logic    advance;

  // The result register can take a new request when it is empty or being
  // drained in this same cycle.
  assign out_free = !out_valid || out_ready;

  // The held byte retires when it produces no result or the result has room.
  assign advance  = hold_valid && (!res.emit || out_free);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte  <= data_byte;
      hold_start <= section_start;
    end
  end

  // The core commits its state only when the held byte retires, so a
  // stalled byte is evaluated again with unchanged state next cycle.
  pmt_parse_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_byte     (hold_byte),
    .section_start (hold_start),
    .res           (res)
  );

  // Result register: loads when a retiring byte produces a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      result_kind    <= res.result_kind;
      prog_num       <= res.prog_num;
      pid            <= res.pid;
      es_type        <= res.es_type;
      info_length    <= res.info_length;
      error_code     <= res.error_code;
    end
  end

endmodule

// ----- tb/tb_pmt_section_parser_top.sv -----
// Self-checking testbench for pmt_section_parser_top: drives PMT section bytes
// over valid/ready and checks every result against a built-in section parser.
// Depends on pmt_pkg and pmt_section_parser_top.
`timescale 1ns / 100ps

module tb_pmt_section_parser_top;
  import pmt_pkg::*;

  // One row of the directed table. When "typed" is set, the result in "want"
  // (or no result at all, if want.emit is low) is taken as written instead of
  // the prediction.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t SHORT_ERR =
    '{1'b1, KIND_ERROR, 16'd0, 13'd0, 8'd0, 12'd0, ERR_TOO_SHORT};
  localparam result_t PROG_ERR =
    '{1'b1, KIND_ERROR, 16'd0, 13'd0, 8'd0, 12'd0, ERR_PROG_OVERRUN};

  // Clock, reset and block ports. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        section_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] prog_num;
  logic [12:0] pid;
  logic [7:0]  es_type;
  logic [11:0] info_length;
  logic [2:0]  error_code;

  // Results the parser model has produced and the block has not delivered yet.
  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned live_bytes = 0;
  int unsigned burst_left = 0;

  // State of the testbench's own section parser.
  phase_t      pr_phase = PH_IDLE;
  logic [12:0] pr_pos = '0;
  logic [12:0] pr_end = '0;
  logic [11:0] pr_skip = '0;
  logic [7:0]  pr_hold = '0;
  logic [12:0] pr_pid = '0;
  logic [7:0]  pr_type = '0;
  logic [15:0] pr_prog = '0;

  // Directed part. It opens with a byte that must be ignored while idle, then
  // a section cut short by a new section start, then a section whose length
  // field is zero (too short), and finally a header of all ones: the largest
  // section length, program number and PCR PID, with a program info length
  // that cannot fit in the section.
  stim_row_t dir_rows [18] = '{
    '{8'hFF, 1'b0, 1'b1, NO_RESULT},
    '{8'h02, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, SHORT_ERR},
    '{8'h02, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b1, PROG_ERR}
  };

  pmt_section_parser_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .section_start  (section_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .prog_num       (prog_num),
    .pid            (pid),
    .es_type        (es_type),
    .info_length    (info_length),
    .error_code     (error_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Any error sends the parser idle and reports only the code.
  function automatic bit parse_error(input logic [2:0] code, output result_t r);
    pr_phase = PH_IDLE;
    r = '0;
    r.emit = 1'b1;
    r.result_kind = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  // Advances the section parser by one accepted byte. Returns 1 and fills r
  // when the byte produces a result.
  function automatic bit pmt_predict_byte(input logic [7:0] b, input logic s,
                                          output result_t r);
    logic [12:0] p;
    logic [11:0] len;
    r = '0;
    if (s) begin
      pr_phase = PH_HEADER;
      pr_pos = '0;
    end
    if (pr_phase == PH_IDLE) return 1'b0;
    p = pr_pos;
    pr_pos = p + 13'd1;
    case (pr_phase)
      PH_HEADER: begin
        case (p)
          POS_LEN_HI, POS_PROG_HI, POS_PCR_HI, POS_PINFO_HI: pr_hold = b;
          POS_LEN_LO: begin
            pr_end = {1'b0, pr_hold[3:0], b} + 13'd3;
            if (int'(pr_end) < HEADER_BYTES + CRC_BYTES)
              return parse_error(ERR_TOO_SHORT, r);
          end
          POS_PROG_LO: pr_prog = {pr_hold, b};
          POS_PCR_LO:  pr_pid = {pr_hold[4:0], b};
          POS_PINFO_LO: begin
            len = {pr_hold[3:0], b};
            if (len != 0 && HEADER_BYTES + int'(len) + CRC_BYTES > int'(pr_end))
              return parse_error(ERR_PROG_OVERRUN, r);
            pr_skip = len;
            pr_phase = (len != 0) ? PH_SKIP_PROG : PH_BOUNDARY;
            r = '{1'b1, KIND_HEADER, pr_prog, pr_pid, 8'd0, len, ERR_NONE};
            return 1'b1;
          end
          default: ;
        endcase
      end
      PH_SKIP_PROG, PH_SKIP_ES: begin
        pr_skip = pr_skip - 12'd1;
        if (pr_skip == 0) pr_phase = PH_BOUNDARY;
      end
      PH_BOUNDARY: begin
        // A boundary byte opens an entry only if a whole entry and the CRC fit.
        if (int'(p) + CRC_BYTES + ENTRY_BYTES <= int'(pr_end)) begin
          pr_type = b;
          pr_phase = PH_PID_HI;
        end else if (int'(p) + CRC_BYTES == int'(pr_end)) begin
          pr_phase = PH_CRC;
        end else begin
          return parse_error(ERR_LEFTOVER, r);
        end
      end
      PH_PID_HI: begin
        pr_hold = b;
        pr_phase = PH_PID_LO;
      end
      PH_PID_LO: begin
        pr_pid = {pr_hold[4:0], b};
        pr_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        pr_hold = b;
        pr_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = {pr_hold[3:0], b};
        if (int'(p) + 1 + int'(len) + CRC_BYTES > int'(pr_end))
          return parse_error(ERR_STREAM_OVERRUN, r);
        pr_skip = len;
        pr_phase = (len != 0) ? PH_SKIP_ES : PH_BOUNDARY;
        r = '{1'b1, KIND_STREAM, pr_prog, pr_pid, pr_type, len, ERR_NONE};
        return 1'b1;
      end
      PH_CRC: begin
        if (int'(p) + 1 >= int'(pr_end)) begin
          pr_phase = PH_IDLE;
          r = '{1'b1, KIND_COMPLETE, pr_prog, 13'd0, 8'd0, 12'd0, ERR_NONE};
          return 1'b1;
        end
      end
      default: pr_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Sender pacing: bursts of random length, each followed by a random gap.
  // A gap of zero is common, so long runs without any idle cycle occur too.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Offers one byte, holds it until the block takes it, then runs the parser
  // model on it. Bytes that the block ignores while idle do not count as live.
  task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                           input result_t want);
    result_t r;
    bit      got;
    bit      ignored;
    pace_sender();
    in_valid <= 1'b1;
    data_byte <= b;
    section_start <= s;
    do @(posedge clk); while (!in_ready);
    ignored = !s && (pr_phase == PH_IDLE);
    got = pmt_predict_byte(b, s, r);
    if (typed) begin
      got = want.emit;
      r = want;
    end
    if (got) pending_results.push_back(r);
    if (!ignored) live_bytes++;
  endtask

  // Lowers valid and waits until every predicted result has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A 12-bit length goes into the low nibble of its high byte; the reserved
  // upper nibble is random.
  function automatic logic [7:0] len_hi(input logic [11:0] n);
    logic [7:0] r8;
    r8 = 8'($urandom);
    return {r8[7:4], n[11:8]};
  endfunction

  // Builds one section with random content and sends it. Most are well formed;
  // the rest get a short or long section length, are cut off by the next
  // section start, or carry random header lengths that reach every length bit.
  task automatic send_random_section();
    logic [7:0]  sec[$];
    logic [11:0] pinfo;
    logic [11:0] es_len;
    logic [11:0] slen;
    int unsigned n_es;
    int unsigned style;
    int unsigned keep;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
    pinfo = ($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
    n_es = $urandom_range(0, 4);
    // Table id, length, program number, version, section numbers, PCR PID.
    repeat (10) sec.push_back(8'($urandom));
    sec.push_back(len_hi(pinfo));
    sec.push_back(pinfo[7:0]);
    repeat (pinfo) sec.push_back(8'($urandom));
    repeat (n_es) begin
      es_len = ($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
      repeat (3) sec.push_back(8'($urandom));
      sec.push_back(len_hi(es_len));
      sec.push_back(es_len[7:0]);
      repeat (es_len) sec.push_back(8'($urandom));
    end
    repeat (CRC_BYTES) sec.push_back(8'($urandom));
    slen = 12'(sec.size() - 3);
    keep = sec.size();
    style = $urandom_range(0, 9);
    case (style)
      6: slen = slen - 12'($urandom_range(1, 6));
      7: slen = slen + 12'($urandom_range(1, 8));
      8: keep = $urandom_range(1, sec.size() - 1);
      9: begin
        slen = 12'($urandom);
        sec[10] = 8'($urandom);
        sec[11] = 8'($urandom);
        keep = $urandom_range(12, 20);
      end
      default: ;
    endcase
    sec[1] = len_hi(slen);
    sec[2] = slen[7:0];
    while (sec.size() > keep) void'(sec.pop_back());
    foreach (sec[k]) send_byte(sec[k], k == 0, 1'b0, NO_RESULT);
  endtask

  task automatic note_bad(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s at %0t: want kind=%0d prog=%h pid=%h type=%h len=%h err=%0d,",
               what, $realtime, want.result_kind, want.prog_num, want.pid,
               want.es_type, want.info_length, want.error_code,
               " got kind=%0d prog=%h pid=%h type=%h len=%h err=%0d",
               got.result_kind, got.prog_num, got.pid,
               got.es_type, got.info_length, got.error_code);
  endtask

  // Result checker: every delivered result is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{1'b1, result_kind, prog_num, pid, es_type, info_length,
              error_code};
      results_seen++;
      if (pending_results.size() == 0) begin
        note_bad("unexpected result", NO_RESULT, got);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind ||
            got.prog_num !== want.prog_num ||
            got.pid !== want.pid || got.es_type !== want.es_type ||
            got.info_length !== want.info_length ||
            got.error_code !== want.error_code)
          note_bad("result mismatch", want, got);
      end
    end
  end

  // Result sink. It switches at random between stall patterns: always ready,
  // coin flip, mostly stalled, or a fixed square wave. Once, after 20 results,
  // it holds off so that the block backs up and stops taking requests.
  initial begin : result_sink
    int unsigned cyc;
    int unsigned mode;
    bit          held_long;
    cyc = 0;
    mode = 0;
    held_long = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && results_seen >= 20) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= cyc[2];
      endcase
      cyc++;
      @(posedge clk);
    end
  end

  // Stimulus: reset, the directed table, then random sections. Halfway through
  // the random part the sender stops until every outstanding result is out.
  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed,
                dir_rows[i].want);
    live_bytes = 0;
    while (live_bytes < 400) begin
      send_random_section();
      if (!paused && live_bytes >= 200) begin
        paused = 1'b1;
        drain_results();
      end
    end
    drain_results();
    // Give a stray extra result time to show up before closing.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Hang guard: far longer than the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pmt_pkg.sv
rtl/core/pmt_parse_core.sv
rtl/core/pmt_section_parser_top.sv
tb/tb_pmt_section_parser_top.sv
